[hw/rtl/cmv_pkg.sv]
package cmv_pkg;

  localparam int WORD_BITS = 16;
  localparam int FRAC_BITS = 12;
  localparam int IN_BITS   = 16;
  localparam int ROWS      = 4;
  localparam int COLS      = 4;
  localparam int RES_N     = 2 * ROWS;
  localparam int PROD_BITS = 2 * WORD_BITS;

  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_DATA = 1'b1;

  typedef logic signed [WORD_BITS-1:0] word_t;

  // One MAC step broadcast to every row lane.
  typedef struct packed {
    logic       issue;
    logic       first;
    logic       odd;
    logic [1:0] col;
  } cmv_step_t;

  // Sign-extend a 16-bit input value, then wrap it to the word format.
  function automatic word_t to_word(logic signed [IN_BITS-1:0] v);
    logic signed [31:0] ext;
    ext = 32'(v);
    return ext[WORD_BITS-1:0];
  endfunction

  // Two's complement view of a word on the 16-bit result field.
  function automatic logic [IN_BITS-1:0] from_word(word_t w);
    logic signed [31:0] ext;
    ext = 32'(w);
    return ext[IN_BITS-1:0];
  endfunction

endpackage

[hw/rtl/cmv_lane.sv]
module cmv_lane
  import cmv_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      wr_en,
  input  logic [1:0] wr_col,
  input  word_t     wr_re,
  input  word_t     wr_im,
  input  cmv_step_t step,
  input  word_t     x_val,
  output word_t     acc_re,
  output word_t     acc_im
);

  word_t bank_re [COLS];
  word_t bank_im [COLS];

  word_t hr;
  word_t hi;
  word_t a_re;
  word_t a_im;
  logic signed [PROD_BITS-1:0] mul_re;
  logic signed [PROD_BITS-1:0] mul_im;
  logic signed [PROD_BITS-1:0] sh_re;
  logic signed [PROD_BITS-1:0] sh_im;

  word_t prod_re;
  word_t prod_im;
  logic  p_valid;
  logic  p_first;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      bank_re[wr_col] <= wr_re;
      bank_im[wr_col] <= wr_im;
    end
  end

  // Even steps take xr, odd steps take xi; the real row uses -Hi on odd steps.
  always_comb begin
    hr     = bank_re[step.col];
    hi     = bank_im[step.col];
    a_re   = step.odd ? word_t'(-hi) : hr;
    a_im   = step.odd ? hr : hi;
    mul_re = PROD_BITS'(a_re) * PROD_BITS'(x_val);
    mul_im = PROD_BITS'(a_im) * PROD_BITS'(x_val);
    sh_re  = mul_re >>> FRAC_BITS;
    sh_im  = mul_im >>> FRAC_BITS;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else begin
      p_valid <= step.issue;
    end
  end

  always_ff @(posedge clk) begin
    p_first <= step.first;
    prod_re <= sh_re[WORD_BITS-1:0];
    prod_im <= sh_im[WORD_BITS-1:0];
    if (p_valid) begin
      acc_re <= (p_first ? word_t'(0) : acc_re) + prod_re;
      acc_im <= (p_first ? word_t'(0) : acc_im) + prod_im;
    end
  end

endmodule

[hw/rtl/cmv_merge.sv]
module cmv_merge
  import cmv_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        load,
  input  word_t       res [RES_N],
  output logic        can_load,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,  // result_value [15:0], result_row [17:16], zero pad
  output logic        m_tuser,  // is_imag
  output logic        m_tlast
);

  word_t      hold [RES_N];
  logic [2:0] idx;
  logic       active;
  logic       beat;

  assign beat     = m_tvalid && m_tready;
  assign can_load = !active || (beat && idx == 3'd7);

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      idx    <= 3'd0;
    end else if (load && can_load) begin
      active <= 1'b1;
      idx    <= 3'd0;
    end else if (beat) begin
      idx <= idx + 3'd1;
      if (idx == 3'd7) begin
        active <= 1'b0;
      end
    end
  end

  // Shift the held results toward the head on every beat that loads no new set.
  always_ff @(posedge clk) begin
    if (load && can_load) begin
      hold <= res;
    end else if (beat) begin
      for (int i = 0; i < RES_N - 1; i++) begin
        hold[i] <= hold[i+1];
      end
    end
  end

  assign m_tvalid = active;
  assign m_tdata  = {6'd0, idx[2:1], from_word(hold[0])};
  assign m_tuser  = idx[0];
  assign m_tlast  = (idx == 3'd7);

endmodule

[hw/rtl/complex_channel_matvec.sv]
// Complex 4x4 channel matrix times 4-element complex vector, fixed point.
//
// Input channel (s_*): one beat per item. s_tuser = 0 loads the next channel
// entry (row-major, 16 entries, then wraps to entry 0); s_tuser = 1 supplies
// the next vector element. Both parts travel in s_tdata.
// Output channel (m_*): after the fourth vector element, 8 beats: real then
// imaginary part of rows 0..3; m_tuser marks the imaginary part, m_tlast the
// eighth beat. The channel stays in place until it is reloaded.
//
// Four row lanes each run an 8-step MAC loop with two multipliers; the loop
// plus a two-stage multiply/accumulate pipe (product register, accumulator)
// keeps s_tready low after the fourth element until the finished vector is
// handed to the output buffer. Load beats go at one per cycle while s_tready
// is high. The 8 results sit in an output buffer, so the next vector
// streams in while they drain. If the receiver stalls, the buffer holds and
// the next finished vector waits in the lanes with s_tready low.
// Reset clears the load and element counters and empties the output buffer;
// channel entries must be loaded before use.
module complex_channel_matvec
  import cmv_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // value_real [15:0], value_imag [31:16]
  input  logic        s_tuser,   // action
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // result_value [15:0], result_row [17:16], zero pad
  output logic        m_tuser,   // is_imag
  output logic        m_tlast
);

  logic       in_acc;
  logic       is_load;
  word_t      in_re;
  word_t      in_im;

  logic [3:0] load_count;
  logic [1:0] elem_count;
  logic       busy;
  logic       issue;
  logic [2:0] k;
  logic       last_d;
  logic       done;
  logic       can_load;

  word_t      vec_re [COLS];
  word_t      vec_im [COLS];
  word_t      x_val;
  cmv_step_t  step;

  word_t      lane_re [ROWS];
  word_t      lane_im [ROWS];
  word_t      res [RES_N];

  assign s_tready = !busy;
  assign in_acc   = s_tvalid && s_tready;
  assign is_load  = (s_tuser == ACT_LOAD);
  assign in_re    = to_word(s_tdata[15:0]);
  assign in_im    = to_word(s_tdata[31:16]);

  always_ff @(posedge clk) begin
    if (rst) begin
      load_count <= 4'd0;
      elem_count <= 2'd0;
      busy       <= 1'b0;
      issue      <= 1'b0;
      k          <= 3'd0;
      last_d     <= 1'b0;
      done       <= 1'b0;
    end else begin
      if (in_acc) begin
        if (is_load) begin
          load_count <= load_count + 4'd1;
        end else begin
          elem_count <= elem_count + 2'd1;
          if (elem_count == 2'd3) begin
            busy  <= 1'b1;
            issue <= 1'b1;
            k     <= 3'd0;
          end
        end
      end
      if (issue) begin
        k <= k + 3'd1;
        if (k == 3'd7) begin
          issue <= 1'b0;
        end
      end
      last_d <= issue && (k == 3'd7);
      if (last_d) begin
        done <= 1'b1;
      end
      // Hand the finished vector to the output buffer and reopen the input.
      if (done && can_load) begin
        done <= 1'b0;
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && !is_load) begin
      vec_re[elem_count] <= in_re;
      vec_im[elem_count] <= in_im;
    end
  end

  assign x_val      = k[0] ? vec_im[k[2:1]] : vec_re[k[2:1]];
  assign step.issue = issue;
  assign step.first = (k == 3'd0);
  assign step.odd   = k[0];
  assign step.col   = k[2:1];

  for (genvar r = 0; r < ROWS; r++) begin : g_lane
    cmv_lane u_lane (
      .clk    (clk),
      .rst    (rst),
      .wr_en  (in_acc && is_load && (load_count[3:2] == 2'(r))),
      .wr_col (load_count[1:0]),
      .wr_re  (in_re),
      .wr_im  (in_im),
      .step   (step),
      .x_val  (x_val),
      .acc_re (lane_re[r]),
      .acc_im (lane_im[r])
    );
    assign res[2*r]   = lane_re[r];
    assign res[2*r+1] = lane_im[r];
  end

  cmv_merge u_merge (
    .clk      (clk),
    .rst      (rst),
    .load     (done),
    .res      (res),
    .can_load (can_load),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

[hw/rtl/cmv_checker.sv]
module cmv_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [23:0] m_tdata,
  input logic        m_tuser,
  input logic        m_tlast
);

  // A stalled beat keeps its payload.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
      && $stable(m_tlast))
    else $error("output beat changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid right after reset");

  a_last_pos: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> m_tuser && (m_tdata[17:16] == 2'd3))
    else $error("last beat is not the imaginary part of row 3");

  // Within a vector the beats come back to back, never with a gap.
  a_no_gap: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && !m_tlast |=> m_tvalid)
    else $error("gap inside a result vector");

  a_row_step: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && !m_tlast && m_tuser |=>
      (m_tdata[17:16] == 2'($past(m_tdata[17:16]) + 2'd1)) && !m_tuser)
    else $error("row index did not advance");

endmodule

bind complex_channel_matvec cmv_checker u_cmv_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);
